// File: hw/rtl/vsrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vsrp_pkg;

   localparam logic [7:0] Sync1Byte  = 8'hAA;
   localparam logic [7:0] Sync2Byte  = 8'h55;
   localparam logic [7:0] MinPayload = 8'd5;
   localparam logic [7:0] MaxPayload = 8'd32;
   localparam logic [7:0] CrcPoly    = 8'hD5;
   localparam int unsigned FieldCount = 5;
   localparam int unsigned QueueDepth = 2;

   localparam logic [1:0] StatusGood   = 2'd0;
   localparam logic [1:0] StatusCrcErr = 2'd1;
   localparam logic [1:0] StatusLenErr = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  command_code;
      logic [7:0]  channel_value;
      logic [7:0]  power_value;
      logic [7:0]  mode_value;
      logic [15:0] frequency_value;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } push_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vsrp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vsrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface vsrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  command_code;
   logic [7:0]  channel_value;
   logic [7:0]  power_value;
   logic [7:0]  mode_value;
   logic [15:0] frequency_value;

   modport source (output valid, output status, output command_code, output channel_value,
                   output power_value, output mode_value, output frequency_value,
                   input ready);
   modport sink (input valid, input status, input command_code, input channel_value,
                 input power_value, input mode_value, input frequency_value,
                 output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vsrp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vsrp_front #(
   parameter logic [7:0] MAX_PAYLOAD = vsrp_pkg::MaxPayload
) (
   input  wire logic       clock,
   input  wire logic       reset,
   vsrp_req_if.sink        req_bus,
   input  wire logic       push_ready,
   output vsrp_pkg::push_type push
);
   import vsrp_pkg::*;

   localparam logic [2:0] PhSync1 = 3'd0;
   localparam logic [2:0] PhSync2 = 3'd1;
   localparam logic [2:0] PhLen   = 3'd2;
   localparam logic [2:0] PhCmd   = 3'd3;
   localparam logic [2:0] PhPay   = 3'd4;
   localparam logic [2:0] PhCrc   = 3'd5;

   localparam int unsigned FieldIdxWidth = $clog2(FieldCount);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] fields_ff [FieldCount];
   logic [7:0] fields_in [FieldCount];
   logic       accept;
   logic [7:0] b;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;
   assign b             = req_bus.rx_byte;

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      command_in = command_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      fields_in  = fields_ff;
      push       = '0;
      if (accept) begin
         unique case (phase_ff)
            PhSync2: begin
               if (b == Sync2Byte) begin
                  phase_in = PhLen;
               end else if (b == Sync1Byte) begin
                  phase_in = PhSync2;
               end else begin
                  phase_in = PhSync1;
               end
            end
            PhLen: begin
               if (b < MinPayload || b > MAX_PAYLOAD) begin
                  phase_in         = PhSync1;
                  push.valid       = 1'b1;
                  push.data.status = StatusLenErr;
               end else begin
                  length_in = b;
                  count_in  = '0;
                  crc_in    = crc8_update(8'd0, b);
                  phase_in  = PhCmd;
               end
            end
            PhCmd: begin
               command_in = b;
               crc_in     = crc8_update(crc_ff, b);
               phase_in   = PhPay;
            end
            PhPay: begin
               if (count_ff < 8'(FieldCount)) begin
                  fields_in[count_ff[FieldIdxWidth-1:0]] = b;
               end
               crc_in   = crc8_update(crc_ff, b);
               count_in = count_ff + 8'd1;
               if (count_in >= length_ff) begin
                  phase_in = PhCrc;
               end
            end
            PhCrc: begin
               phase_in                  = PhSync1;
               push.valid                = 1'b1;
               push.data.status          = (b == crc_ff) ? StatusGood : StatusCrcErr;
               push.data.command_code    = command_ff;
               push.data.channel_value   = fields_ff[0];
               push.data.power_value     = fields_ff[1];
               push.data.mode_value      = fields_ff[2];
               push.data.frequency_value = {fields_ff[3], fields_ff[4]};
            end
            default: begin
               phase_in = (b == Sync1Byte) ? PhSync2 : PhSync1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhSync1;
         length_ff  <= '0;
         command_ff <= '0;
         count_ff   <= '0;
         crc_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         count_ff   <= count_in;
         crc_ff     <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      fields_ff <= fields_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/vsrp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module vsrp_queue #(
   parameter int unsigned QUEUE_DEPTH = vsrp_pkg::QueueDepth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vsrp_pkg::push_type   push,
   output logic                      push_ready,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output vsrp_pkg::result_type      pop_data
);
   import vsrp_pkg::*;

   localparam int unsigned PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(QUEUE_DEPTH);

   result_type              data_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = data_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/vsrp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vsrp_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            pop_valid,
   output logic                 pop_ready,
   input  wire vsrp_pkg::result_type pop_data,
   vsrp_rsp_if.source           rsp_bus
);
   import vsrp_pkg::*;

   logic       valid_ff, valid_in;
   result_type rsp_ff;

   assign pop_ready = !valid_ff || rsp_bus.ready;
   assign valid_in  = pop_valid || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         rsp_ff <= pop_data;
      end
   end

   assign rsp_bus.valid           = valid_ff;
   assign rsp_bus.status          = rsp_ff.status;
   assign rsp_bus.command_code    = rsp_ff.command_code;
   assign rsp_bus.channel_value   = rsp_ff.channel_value;
   assign rsp_bus.power_value     = rsp_ff.power_value;
   assign rsp_bus.mode_value      = rsp_ff.mode_value;
   assign rsp_bus.frequency_value = rsp_ff.frequency_value;

endmodule
`default_nettype wire

// File: hw/rtl/vtx_settings_response_parser_core.sv
// Settings response parser: takes received UART bytes on req_bus, one item per
// byte, and returns one item on rsp_bus for each frame it closes.
// Frame: 0xAA 0x55, length, command, payload (length bytes), CRC-8/DVB-S2 over
// length, command and payload. Length must be 5..MAX_PAYLOAD (32 by default);
// otherwise a status 2 item with zero fields goes out right after the length
// byte. Status 0 is a good frame, 1 a CRC mismatch; fields carry command and
// payload bytes 0..4. After every frame the parser hunts for sync again.
// Throughput: one byte per cycle while the queue has room; the per-byte CRC update and phase step
// finish in the cycle the byte is taken.
// Path: the result is pushed in the cycle the closing byte is accepted, then
// registered in the queue and again in the output register before it is valid
// on rsp_bus (front parser -> QUEUE_DEPTH-entry queue, 2 by default -> output register).
// Reset (synchronous, active high) returns the parser to the sync hunt and
// empties the queue and output register.
// When rsp_bus stalls, results pile up in the queue; req_bus.ready drops only
// once the queue is full, so a stalled receiver back-pressures the byte stream.
`timescale 1ns / 1ps
`default_nettype none
module vtx_settings_response_parser_core #(
   parameter logic [7:0]  MAX_PAYLOAD = vsrp_pkg::MaxPayload,
   parameter int unsigned QUEUE_DEPTH = vsrp_pkg::QueueDepth
) (
   input  wire logic  clock,
   input  wire logic  reset,
   vsrp_req_if.sink   req_bus,
   vsrp_rsp_if.source rsp_bus
);
   import vsrp_pkg::*;

   push_type   push;
   logic       push_ready;
   logic       pop_valid;
   logic       pop_ready;
   result_type pop_data;

   vsrp_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_ready (push_ready),
      .push       (push)
   );

   vsrp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   vsrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_bus   (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready)
      else $error("result pushed into full queue");

   a_full_means_stalled: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> rsp_bus.valid)
      else $error("queue full while output register empty");

   a_len_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == StatusLenErr) |->
      (rsp_bus.command_code == 8'd0 && rsp_bus.channel_value == 8'd0 &&
       rsp_bus.power_value == 8'd0 && rsp_bus.mode_value == 8'd0 &&
       rsp_bus.frequency_value == 16'd0))
      else $error("length error item carries nonzero fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.data.status == StatusGood || push.data.status == StatusCrcErr ||
                      push.data.status == StatusLenErr))
      else $error("bad status code pushed");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import vsrp_pkg::*;

   typedef enum logic [2:0] {
      HUNT_SYNC1, WAIT_SYNC2, TAKE_LEN, TAKE_CMD, TAKE_PAYLOAD, TAKE_CRC
   } parse_phase_type;

   typedef enum logic [1:0] {ROW_PLAIN, ROW_CRC_OK, ROW_LEN_ERR} row_kind_type;

   typedef struct {
      logic [7:0]   data;
      row_kind_type kind;
   } stim_row_type;

   logic clock;
   logic reset;

   vsrp_req_if req_bus ();
   vsrp_rsp_if rsp_bus ();

   vtx_settings_response_parser_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predictor state
   parse_phase_type pred_phase;
   logic [7:0]   pred_len;
   logic [7:0]   pred_cmd;
   logic [7:0]   pred_count;
   logic [7:0]   pred_crc;
   logic [7:0]   pred_fields [0:4];

   result_type  pending_results [$];
   int unsigned bytes_sent;
   int unsigned results_checked;
   int unsigned mismatches;
   int unsigned status_count [0:3];
   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;
   int unsigned hold_left;

   stim_row_type directed_rows [26] = '{
      '{8'h00, ROW_PLAIN},
      '{8'hAA, ROW_PLAIN}, '{8'h12, ROW_PLAIN},
      '{8'hAA, ROW_PLAIN}, '{8'h55, ROW_PLAIN}, '{8'h04, ROW_LEN_ERR},
      '{8'hAA, ROW_PLAIN}, '{8'hAA, ROW_PLAIN}, '{8'h55, ROW_PLAIN}, '{8'h21, ROW_LEN_ERR},
      '{8'hAA, ROW_PLAIN}, '{8'h55, ROW_PLAIN}, '{8'h00, ROW_LEN_ERR},
      '{8'hAA, ROW_PLAIN}, '{8'h55, ROW_PLAIN}, '{8'hFF, ROW_LEN_ERR},
      '{8'hAA, ROW_PLAIN}, '{8'h55, ROW_PLAIN}, '{8'h05, ROW_PLAIN}, '{8'hC3, ROW_PLAIN},
      '{8'hFF, ROW_PLAIN}, '{8'h00, ROW_PLAIN}, '{8'h80, ROW_PLAIN}, '{8'h01, ROW_PLAIN},
      '{8'hFE, ROW_PLAIN}, '{8'h00, ROW_CRC_OK}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("timeout with %0d results pending", pending_results.size());
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] c;
      c = acc ^ d;
      for (int i = 0; i < 8; i++) c = {c[6:0], 1'b0} ^ (c[7] ? CrcPoly : 8'h00);
      return c;
   endfunction

   function automatic bit parse_predict(input logic [7:0] b, output result_type r);
      bit made;
      made = 1'b0;
      r = '0;
      case (pred_phase)
         WAIT_SYNC2: begin
            if (b == Sync2Byte) pred_phase = TAKE_LEN;
            else if (b == Sync1Byte) pred_phase = WAIT_SYNC2;
            else pred_phase = HUNT_SYNC1;
         end
         TAKE_LEN: begin
            if (b < MinPayload || b > MaxPayload) begin
               pred_phase = HUNT_SYNC1;
               r.status = StatusLenErr;
               made = 1'b1;
            end else begin
               pred_len = b;
               pred_count = 8'd0;
               pred_crc = crc_step(8'h00, b);
               pred_phase = TAKE_CMD;
            end
         end
         TAKE_CMD: begin
            pred_cmd = b;
            pred_crc = crc_step(pred_crc, b);
            pred_phase = TAKE_PAYLOAD;
         end
         TAKE_PAYLOAD: begin
            if (pred_count < FieldCount) pred_fields[pred_count] = b;
            pred_crc = crc_step(pred_crc, b);
            pred_count = pred_count + 8'd1;
            if (pred_count >= pred_len) pred_phase = TAKE_CRC;
         end
         TAKE_CRC: begin
            pred_phase = HUNT_SYNC1;
            r.status = (b == pred_crc) ? StatusGood : StatusCrcErr;
            r.command_code = pred_cmd;
            r.channel_value = pred_fields[0];
            r.power_value = pred_fields[1];
            r.mode_value = pred_fields[2];
            r.frequency_value = {pred_fields[3], pred_fields[4]};
            made = 1'b1;
         end
         default: begin
            pred_phase = (b == Sync1Byte) ? WAIT_SYNC2 : HUNT_SYNC1;
         end
      endcase
      return made;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_byte(input logic [7:0] b, input bit typed, input result_type typed_res);
      result_type r;
      bit made;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      made = parse_predict(b, r);
      if (typed) pending_results.push_back(typed_res);
      else if (made) pending_results.push_back(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic put(input logic [7:0] b);
      send_byte(b, 1'b0, '0);
   endtask

   task automatic send_random_frame();
      int unsigned sel;
      int unsigned lsel;
      int unsigned k;
      logic [7:0] len;
      if ($urandom_range(99) < 20) begin
         k = $urandom_range(1, 3);
         repeat (k) put(8'($urandom_range(255)));
      end
      sel = $urandom_range(99);
      if (sel < 8) begin
         put(Sync1Byte);
         put(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(99) < 15) put(Sync1Byte);
      put(Sync1Byte);
      put(Sync2Byte);
      if (sel < 16) begin
         if ($urandom_range(1)) put(8'($urandom_range(0, MinPayload - 1)));
         else put(8'($urandom_range(MaxPayload + 1, 255)));
         return;
      end
      lsel = $urandom_range(99);
      if (lsel < 5) len = MaxPayload;
      else if (lsel < 15) len = 8'($urandom_range(9, MaxPayload));
      else len = 8'($urandom_range(MinPayload, 8));
      put(len);
      put(8'($urandom_range(255)));
      if (sel < 22) begin
         // cut short: the next frame's bytes land in this payload
         repeat ($urandom_range(0, len - 1)) put(8'($urandom_range(255)));
         return;
      end
      repeat (len) put(8'($urandom_range(255)));
      if ($urandom_range(99) < 85) put(pred_crc);
      else put(pred_crc ^ 8'($urandom_range(1, 255)));
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("result item with nothing pending");
         end else begin
            want = pending_results.pop_front();
            check_field("status", 16'(rsp_bus.status), 16'(want.status));
            check_field("command_code", 16'(rsp_bus.command_code), 16'(want.command_code));
            check_field("channel_value", 16'(rsp_bus.channel_value), 16'(want.channel_value));
            check_field("power_value", 16'(rsp_bus.power_value), 16'(want.power_value));
            check_field("mode_value", 16'(rsp_bus.mode_value), 16'(want.mode_value));
            check_field("frequency_value", rsp_bus.frequency_value, want.frequency_value);
            results_checked++;
            status_count[want.status]++;
         end
      end
   end

   initial begin
      result_type len_err_res;
      int unsigned target;
      len_err_res = '0;
      len_err_res.status = StatusLenErr;
      pred_phase = HUNT_SYNC1;
      pred_len = 8'd0;
      pred_cmd = 8'd0;
      pred_count = 8'd0;
      pred_crc = 8'd0;
      for (int i = 0; i < 5; i++) pred_fields[i] = 8'd0;
      for (int i = 0; i < 4; i++) status_count[i] = 0;
      bytes_sent = 0;
      results_checked = 0;
      mismatches = 0;
      src_idle_pct = 0;
      snk_stall_pct = 0;
      hold_left = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_LEN_ERR: send_byte(directed_rows[i].data, 1'b1, len_err_res);
            ROW_CRC_OK:  put(pred_crc);
            default:     put(directed_rows[i].data);
         endcase
      end

      // long receiver hold-off while frames keep coming
      req_bus.valid <= 1'b0;
      @(posedge clock);
      hold_left = 400;
      @(negedge clock);
      repeat (12) begin
         put(Sync1Byte);
         put(Sync2Byte);
         put(MinPayload);
         repeat (MinPayload + 1) put(8'($urandom_range(255)));
         put(pred_crc);
      end

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 77; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 77; end
            default: begin src_idle_pct = 37; snk_stall_pct = 37; end
         endcase
         target = bytes_sent + 160;
         while (bytes_sent < target) send_random_frame();
      end

      req_bus.valid <= 1'b0;
      src_idle_pct = 0;
      snk_stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d bytes, checked %0d frame results", bytes_sent, results_checked);
      $display("status good %0d, crc error %0d, length error %0d",
               status_count[StatusGood], status_count[StatusCrcErr],
               status_count[StatusLenErr]);
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
